[rtl/b58_pkg.sv]
package b58_pkg;

  // Radix of the digit store and the divide-by-radix reciprocal.
  localparam int unsigned RADIX       = 58;
  localparam int unsigned RECIP       = 1130;
  localparam int unsigned RECIP_SHIFT = 16;

  // Digits needed per payload byte, as the ratio log(256)/log(58) rounded up.
  localparam int unsigned DIGIT_NUM = 138;
  localparam int unsigned DIGIT_DEN = 100;

  // Most characters emitted for one payload, and the width of that count.
  localparam int unsigned MAX_OUT = 64;
  localparam int unsigned OW      = 7;

  // Widths of the fold arithmetic.
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CARRY_W = 8;
  localparam int unsigned VALUE_W = 14;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam logic [7:0] ALPHABET [RADIX] = '{
    "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M", "N", "P", "Q", "R",
    "S", "T", "U", "V", "W", "X", "Y", "Z",
    "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k", "m", "n", "o", "p", "q",
    "r", "s", "t", "u", "v", "w", "x", "y", "z"
  };

  // Maps one stored digit to its character; a code past the radix reads as digit zero.
  function automatic char_t digit_char(digit_t d);
    char_t c;
    if (d < DIGIT_W'(RADIX)) begin
      c = ALPHABET[d][CHAR_W-1:0];
    end else begin
      c = ALPHABET[0][CHAR_W-1:0];
    end
    return c;
  endfunction

endpackage

[rtl/b58_if.sv]
// Byte channel into the encoder.
interface b58_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// Character channel out of the encoder.
interface b58_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol_char;
  logic       last_symbol;
  logic       overflowed;

  modport source (output valid, output symbol_char, output last_symbol, output overflowed,
                  input ready);
  modport sink   (input valid, input symbol_char, input last_symbol, input overflowed,
                  output ready);
endinterface

[rtl/b58_ram.sv]
module b58_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 45
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/b58_div58.sv]
module b58_div58 (
  input  logic [b58_pkg::VALUE_W-1:0] value,
  output logic [b58_pkg::CARRY_W-1:0] quo,
  output b58_pkg::digit_t             rem
);

  localparam int unsigned PW = b58_pkg::VALUE_W + 11;

  logic [PW-1:0]               prod;
  logic [b58_pkg::VALUE_W-1:0] quo_ext;
  logic [b58_pkg::VALUE_W-1:0] back;

  // Reciprocal multiply; exact for every value the fold can produce (below 14848).
  assign prod    = PW'(value) * PW'(b58_pkg::RECIP);
  assign quo_ext = b58_pkg::VALUE_W'(prod >> b58_pkg::RECIP_SHIFT);
  assign quo     = quo_ext[b58_pkg::CARRY_W-1:0];

  // Quotient times 58 as 64 - 4 - 2, then the remainder.
  assign back = (quo_ext << 6) - (quo_ext << 2) - (quo_ext << 1);
  assign rem  = b58_pkg::DIGIT_W'(value - back);

endmodule

[rtl/base58_encoder.sv]
// Base-58 encoder with the usual alphabet ('1'..'9', 'A'..'Z', 'a'..'z' without 0, O, I, l).
// The in_ch channel takes one payload byte per item, most significant first, with
// is_last on the final byte. The out_ch channel gives the encoded string, one
// character per item, with last_symbol on its final character and overflowed set
// on every character when the payload had more than MAX_BYTES bytes (extra bytes
// are dropped; a dropped final byte still ends the payload).
// Each byte is folded into a digit memory with a read-modify-write walk, one
// digit per cycle through the divide-by-58 unit, over the current digit count
// (up to 45 for 32 bytes), then any carry left is appended as new digits.
// in_ch is ready only while no byte or string is in work. After the final byte
// the string follows, at most 64 characters: each leading '1' goes straight to
// the output register, each digit character by a memory read, then that register.
// The output register holds a character while out_ch is stalled, and the next
// payload's first byte may be taken while the last character still waits.
// Synchronous reset empties the digit memory logically: the digit count acts as
// fill count, so no clearing pass is needed; the block is ready straight after.
module base58_encoder #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  b58_in_if.sink       in_ch,
  b58_out_if.source    out_ch
);

  localparam int unsigned DEPTH = MAX_BYTES * b58_pkg::DIGIT_NUM / b58_pkg::DIGIT_DEN + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned BW    = $clog2(MAX_BYTES + 1);
  localparam int unsigned MW    = (BW > CW) ? BW : CW;
  localparam int unsigned SW    = ((MW > b58_pkg::OW) ? MW : b58_pkg::OW) + 1;
  localparam int unsigned OW    = b58_pkg::OW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FOLD   = 3'd1;
  localparam logic [2:0] ST_APPEND = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_RDATA  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               dcount_r, dcount_nxt;
  logic [BW-1:0]               zpc_r, zpc_nxt;
  logic                        in_zp_r, in_zp_nxt;
  logic [BW-1:0]               bytes_r, bytes_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        last_r, last_nxt;
  logic                        fresh_r, fresh_nxt;
  logic [b58_pkg::CARRY_W-1:0] carry_r, carry_nxt;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [AW-1:0]               dptr_r, dptr_nxt;
  logic [BW-1:0]               zleft_r, zleft_nxt;
  logic [OW-1:0]               rem_r, rem_nxt;

  logic                        out_valid_r, out_valid_nxt;
  b58_pkg::char_t              out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  b58_pkg::digit_t             ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  b58_pkg::digit_t             ram_rdata;

  logic [b58_pkg::VALUE_W-1:0] div_in;
  logic [b58_pkg::CARRY_W-1:0] div_quo;
  b58_pkg::digit_t             div_rem;

  logic                        in_acc;
  logic                        out_free;
  b58_pkg::digit_t             fold_digit;
  logic [BW-1:0]               zeros;
  logic [SW-1:0]               total;

  b58_ram #(
    .WIDTH (b58_pkg::DIGIT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  b58_div58 u_div (
    .value (div_in),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol_char = out_char_r;
  assign out_ch.last_symbol = out_last_r;
  assign out_ch.overflowed  = out_ovf_r;

  // Digit zero of a fresh payload has never been written this time and reads as zero.
  assign fold_digit = (fresh_r && (idx_r == '0)) ? '0 : ram_rdata;

  // The divider sees a stored digit shifted up plus carry while folding, the carry alone
  // while appending.
  always_comb begin
    if (state_r == ST_FOLD) begin
      div_in = {fold_digit, {b58_pkg::CARRY_W{1'b0}}} + b58_pkg::VALUE_W'(carry_r);
    end else begin
      div_in = b58_pkg::VALUE_W'(carry_r);
    end
  end

  // Leading '1' count (the final byte never counts) and the uncapped string length.
  assign zeros = (in_zp_r && (zpc_r != '0)) ? zpc_r - 1'b1 : zpc_r;
  assign total = SW'(zeros) + SW'(dcount_r);

  // Sequencer: fold walk, append, then string output.
  always_comb begin
    state_nxt     = state_r;
    dcount_nxt    = dcount_r;
    zpc_nxt       = zpc_r;
    in_zp_nxt     = in_zp_r;
    bytes_nxt     = bytes_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    fresh_nxt     = fresh_r;
    carry_nxt     = carry_r;
    idx_nxt       = idx_r;
    dptr_nxt      = dptr_r;
    zleft_nxt     = zleft_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = div_rem;
    ram_re        = 1'b0;
    ram_raddr     = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_ch.is_last;
          if (bytes_r < BW'(MAX_BYTES)) begin
            bytes_nxt = bytes_r + 1'b1;
            fresh_nxt = (bytes_r == '0);
            if (in_zp_r) begin
              if (in_ch.data_byte == 8'd0) begin
                zpc_nxt = zpc_r + 1'b1;
              end else begin
                in_zp_nxt = 1'b0;
              end
            end
            carry_nxt = in_ch.data_byte;
            idx_nxt   = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_nxt = ST_FOLD;
          end else begin
            ovf_nxt = 1'b1;
            if (in_ch.is_last) begin
              zleft_nxt = zeros;
              rem_nxt   = (total > SW'(b58_pkg::MAX_OUT)) ? OW'(b58_pkg::MAX_OUT) : OW'(total);
              dptr_nxt  = AW'(dcount_r - 1'b1);
              state_nxt = ST_EMIT;
            end
          end
        end
      end

      ST_FOLD: begin
        // Write back the updated digit while the next one is read.
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        carry_nxt = div_quo;
        if ((CW'(idx_r) + 1'b1) < dcount_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          state_nxt = ST_APPEND;
        end
      end

      ST_APPEND: begin
        if ((carry_r != '0) && (dcount_r < CW'(DEPTH))) begin
          ram_we     = 1'b1;
          ram_waddr  = AW'(dcount_r);
          carry_nxt  = div_quo;
          dcount_nxt = dcount_r + 1'b1;
        end else if (last_r) begin
          zleft_nxt = zeros;
          rem_nxt   = (total > SW'(b58_pkg::MAX_OUT)) ? OW'(b58_pkg::MAX_OUT) : OW'(total);
          dptr_nxt  = AW'(dcount_r - 1'b1);
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (zleft_r != '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = b58_pkg::CHAR_ONE;
            out_last_nxt  = (rem_r == OW'(1));
            out_ovf_nxt   = ovf_r;
            zleft_nxt     = zleft_r - 1'b1;
            rem_nxt       = rem_r - 1'b1;
            if (rem_r == OW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = dptr_r;
          state_nxt = ST_RDATA;
        end
      end

      ST_RDATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = b58_pkg::digit_char(ram_rdata);
          out_last_nxt  = (rem_r == OW'(1));
          out_ovf_nxt   = ovf_r;
          dptr_nxt      = dptr_r - 1'b1;
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == OW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // The string is complete: clear the payload state for the next one.
    if (((state_r == ST_EMIT) || (state_r == ST_RDATA)) && (state_nxt == ST_IDLE)) begin
      dcount_nxt = CW'(1);
      zpc_nxt    = '0;
      in_zp_nxt  = 1'b1;
      bytes_nxt  = '0;
      ovf_nxt    = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dcount_r    <= CW'(1);
      zpc_r       <= '0;
      in_zp_r     <= 1'b1;
      bytes_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcount_r    <= dcount_nxt;
      zpc_r       <= zpc_nxt;
      in_zp_r     <= in_zp_nxt;
      bytes_r     <= bytes_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    fresh_r    <= fresh_nxt;
    carry_r    <= carry_nxt;
    idx_r      <= idx_nxt;
    dptr_r     <= dptr_nxt;
    zleft_r    <= zleft_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule
